>>> rtl/iir_direct_form_filter_core_assert.svh
// Assertion macros for the direct-form-I IIR filter core.
// Each macro checks a property on the rising edge of clk, with checking
// suspended while rst_n is low.
`ifndef IIR_DIRECT_FORM_FILTER_CORE_ASSERT_SVH
`define IIR_DIRECT_FORM_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define IIRDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IIRDF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define IIRDF_ASSERT(lbl, prop, msg)
`define IIRDF_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

>>> rtl/iirdf_pkg.sv
`timescale 1ns / 1ps

package iirdf_pkg;

    // Sample and coefficient formats
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 24;
    localparam int FRAC_BITS = 20;
    localparam int HIST_D    = 3;
    localparam int ORDER_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    // Datapath widths: one product, and a sum of up to seven products with headroom
    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int YW     = ACC_W - FRAC_BITS;
    localparam int STEP_W = 3;

    localparam logic [ORDER_W-1:0] ORDER_MAX = 3'd4;
    localparam logic [ORDER_W-1:0] ORDER_RST = 3'd4;

    localparam logic signed [COEF_W-1:0]   COEF_ONE   = 24'sd1048576;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [YW-1:0]       Y_HI       = YW'(SAMPLE_MAX);
    localparam logic signed [YW-1:0]       Y_LO       = YW'(SAMPLE_MIN);
    localparam logic signed [ACC_W-1:0]    RND_HALF   = ACC_W'(2 ** (FRAC_BITS - 1));

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_ORDER,
        REG_COEF_B0,
        REG_COEF_B1,
        REG_COEF_B2,
        REG_COEF_B3,
        REG_COEF_A1,
        REG_COEF_A2,
        REG_COEF_A3
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_LAST,
        S_ROUND
    } seq_state_t;

endpackage

>>> rtl/iir_direct_form_filter_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                   Payload
// sample    sample_valid/sample_stall   sample_in
// result    result_valid/result_stall   sample_out, saturated
// config    cfg_we                      cfg_index, cfg_data
//
// A sample passes from acceptance to a valid result in these steps (N taps, 1 to 4):
// one shared 24x16 multiplier steps through the 2*N-1 products in S_MAC, S_LAST adds the last
// product and S_ROUND rounds; a new sample is taken only once the sequencer is back in S_IDLE.
// Reset clears the histories and loads b0 = 1.0, the other coefficients zero, four taps.
// A stalled result holds the rounding step; the next sample is taken while a finished
// result still waits on the output register.

`include "iir_direct_form_filter_core_assert.svh"

module iir_direct_form_filter_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [iirdf_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [iirdf_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                 saturated,
    input  logic                                 cfg_we,
    input  logic [iirdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iirdf_pkg::CFG_W-1:0]          cfg_data
);

    import iirdf_pkg::*;

    seq_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [ORDER_W-1:0]       order_reg;
    logic signed [COEF_W-1:0] coef_b_reg [0:3];
    logic signed [COEF_W-1:0] coef_a_reg [1:3];

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] xh_reg [0:HIST_D-1];
    logic signed [SAMPLE_W-1:0] yh_reg [0:HIST_D-1];

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg, prod_vld_next;
    logic                     prod_sub_reg, prod_sub_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic                       result_valid_reg, result_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       saturated_reg;

    logic [ORDER_W-1:0]       taps_eff;
    logic [STEP_W-1:0]        last_step;
    logic signed [COEF_W-1:0] op_coef;
    logic signed [SAMPLE_W-1:0] op_smp;
    logic                     op_sub;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [YW-1:0]     y_wide;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                     y_clip;
    logic                     accept;
    logic                     finish;

    // Handshake outputs
    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = result_valid_reg;
    assign sample_out   = sample_out_reg;
    assign saturated    = saturated_reg;
    assign finish       = (state_reg == S_ROUND) && !(result_valid_reg && result_stall);

    // Effective tap count and index of the last product
    always_comb
    begin
        if (order_reg == '0)
        begin
            taps_eff = ORDER_W'(1);
        end
        else if (order_reg > ORDER_MAX)
        begin
            taps_eff = ORDER_MAX;
        end
        else
        begin
            taps_eff = order_reg;
        end
        last_step = STEP_W'({taps_eff, 1'b0} - 4'd2);
    end

    // Operand selection: step 0 is b0*x, odd steps b_i*x[n-i], even steps a_i*y[n-i]
    always_comb
    begin
        op_coef = coef_b_reg[0];
        op_smp  = x_reg;
        op_sub  = 1'b0;
        unique case (step_reg)
            3'd0:
            begin
                op_coef = coef_b_reg[0];
                op_smp  = x_reg;
            end
            3'd1:
            begin
                op_coef = coef_b_reg[1];
                op_smp  = xh_reg[0];
            end
            3'd2:
            begin
                op_coef = coef_a_reg[1];
                op_smp  = yh_reg[0];
                op_sub  = 1'b1;
            end
            3'd3:
            begin
                op_coef = coef_b_reg[2];
                op_smp  = xh_reg[1];
            end
            3'd4:
            begin
                op_coef = coef_a_reg[2];
                op_smp  = yh_reg[1];
                op_sub  = 1'b1;
            end
            3'd5:
            begin
                op_coef = coef_b_reg[3];
                op_smp  = xh_reg[2];
            end
            3'd6:
            begin
                op_coef = coef_a_reg[3];
                op_smp  = yh_reg[2];
                op_sub  = 1'b1;
            end
            default:
            begin
                op_coef = coef_b_reg[0];
                op_smp  = x_reg;
                op_sub  = 1'b0;
            end
        endcase
    end

    // Rounding to nearest (ties upwards) and saturation
    always_comb
    begin
        rnd_sum = acc_reg + RND_HALF;
        y_wide  = rnd_sum[ACC_W-1:FRAC_BITS];
        if (y_wide > Y_HI)
        begin
            y_sat  = SAMPLE_MAX;
            y_clip = 1'b1;
        end
        else if (y_wide < Y_LO)
        begin
            y_sat  = SAMPLE_MIN;
            y_clip = 1'b1;
        end
        else
        begin
            y_sat  = y_wide[SAMPLE_W-1:0];
            y_clip = 1'b0;
        end
    end

    // Accumulator update from the registered product
    always_comb
    begin
        if (accept)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg && prod_sub_reg)
        begin
            acc_next = acc_reg - ACC_W'(prod_reg);
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    // Sequencer: next state and step control
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        prod_vld_next     = 1'b0;
        prod_sub_next     = op_sub;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MAC;
                    step_next  = '0;
                end
            end
            S_MAC:
            begin
                prod_vld_next = 1'b1;
                if (step_reg >= last_step)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_LAST:
            begin
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (finish)
                begin
                    state_next        = S_IDLE;
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            prod_vld_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            prod_vld_reg     <= prod_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= ORDER_RST;
            coef_b_reg[0] <= COEF_ONE;
            coef_b_reg[1] <= '0;
            coef_b_reg[2] <= '0;
            coef_b_reg[3] <= '0;
            coef_a_reg[1] <= '0;
            coef_a_reg[2] <= '0;
            coef_a_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_ORDER: order_reg     <= cfg_data[ORDER_W-1:0];
                REG_COEF_B0:      coef_b_reg[0] <= cfg_data;
                REG_COEF_B1:      coef_b_reg[1] <= cfg_data;
                REG_COEF_B2:      coef_b_reg[2] <= cfg_data;
                REG_COEF_B3:      coef_b_reg[3] <= cfg_data;
                REG_COEF_A1:      coef_a_reg[1] <= cfg_data;
                REG_COEF_A2:      coef_a_reg[2] <= cfg_data;
                REG_COEF_A3:      coef_a_reg[3] <= cfg_data;
                default:          order_reg     <= order_reg;
            endcase
        end
    end

    // Sample histories: shift once per completed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_D; i++)
            begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end
        else if (finish)
        begin
            for (int i = HIST_D - 1; i > 0; i--)
            begin
                xh_reg[i] <= xh_reg[i-1];
                yh_reg[i] <= yh_reg[i-1];
            end
            xh_reg[0] <= x_reg;
            yh_reg[0] <= y_sat;
        end
    end

    // Datapath registers: shared multiplier, accumulator and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample_in;
        end
        prod_reg     <= PROD_W'(op_coef) * PROD_W'(op_smp);
        prod_sub_reg <= prod_sub_next;
        acc_reg      <= acc_next;
        if (finish)
        begin
            sample_out_reg <= y_sat;
            saturated_reg  <= y_clip;
        end
    end

    // Checks on the sequencer and the result path
    `IIRDF_ASSERT(a_step_in_range, state_reg != S_MAC || step_reg <= last_step, "step past last tap")
    `IIRDF_ASSERT(a_prod_only_busy, !prod_vld_reg || state_reg == S_MAC || state_reg == S_LAST, "product outside MAC")
    `IIRDF_ASSERT_NEXT(a_hist_matches_out, finish, result_valid && sample_out == yh_reg[0], "history mismatch")
    `IIRDF_ASSERT(a_sat_at_rail, !(result_valid && saturated) || sample_out == SAMPLE_MAX || sample_out == SAMPLE_MIN, "clip not at rail")

endmodule
